### src/klock_pkg.sv
// Shared types, constants and codes for the keypad code lock.
`timescale 1ns / 1ps

package klock_pkg;

    localparam int MAX_CODE_LEN = 16;
    localparam int ADDR_W       = $clog2(MAX_CODE_LEN);
    localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);
    localparam int LED_COUNT    = 5;
    localparam int SWEEP_W      = $clog2(LED_COUNT);
    localparam int LED_W        = 5;
    localparam int KEY_W        = 4;
    localparam int OP_W         = 3;
    localparam int PULSE_W      = 13;
    localparam int FLASH_W      = 8;

    localparam int S_TDATA_W    = 8;
    localparam int S_TUSER_W    = OP_W;
    localparam int M_TDATA_W    = 24;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    localparam logic [KEY_W-1:0]   KEY_HASH          = 4'd14;
    localparam logic [LED_W-1:0]   LED_ALL           = LED_W'((1 << LED_COUNT) - 1);
    localparam logic [PULSE_W-1:0] LOCK_PULSE_RESET  = 13'd271;
    localparam logic [PULSE_W-1:0] OPEN_PULSE_RESET  = 13'd1;
    localparam logic [FLASH_W-1:0] FLASH_TICKS_RESET = 8'd2;

    // Register index, taken from paddr[3:2].
    localparam logic [1:0] REG_LOCK_PULSE  = 2'd0;
    localparam logic [1:0] REG_OPEN_PULSE  = 2'd1;
    localparam logic [1:0] REG_FLASH_TICKS = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_KEY           = 3'd0,
        OP_BOX_CLOSED    = 3'd1,
        OP_RESET_PRESS   = 3'd2,
        OP_RESET_RELEASE = 3'd3,
        OP_TICK          = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CMP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic cmp_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic need_cmp;
        logic cmp_done;
    } status_t;

    // Declared from the top bit down, so is_locked lands in bit 0.
    typedef struct packed {
        logic               pad;
        logic               store_full;
        logic               attempt_match;
        logic               attempt_done;
        logic [LED_W-1:0]   leds;
        logic [PULSE_W-1:0] servo_pulse;
        logic               code_set;
        logic               is_locked;
    } result_t;

endpackage

### src/klock_ctrl.sv
// Controller state machine that sequences one event through the datapath.
`timescale 1ns / 1ps

module klock_ctrl
    import klock_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  logic    out_free,
    input  status_t status,
    output logic    s_tready,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = status.need_cmp ? ST_CMP : ST_FINISH;
            end
            ST_CMP: begin
                if (status.cmp_done) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            ST_CMP: begin
                cmd.cmp_step = 1'b1;
            end
            ST_FINISH: begin
                cmd.emit = out_free;
            end
            default: ;
        endcase
    end

endmodule

### src/klock_dp.sv
// Datapath: code and entry stores, lock state, digit compare walk and LED logic.
`timescale 1ns / 1ps

module klock_dp
    import klock_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    input  logic [OP_W-1:0]    in_opcode,
    input  logic [KEY_W-1:0]   in_key,
    input  logic [PULSE_W-1:0] lock_pulse,
    input  logic [PULSE_W-1:0] open_pulse,
    input  logic [FLASH_W-1:0] flash_ticks,
    output status_t            status,
    output result_t            result
);

    logic [KEY_W-1:0] code_mem  [MAX_CODE_LEN];
    logic [KEY_W-1:0] entry_mem [MAX_CODE_LEN];
    logic [KEY_W-1:0] code_rd_reg;
    logic [KEY_W-1:0] entry_rd_reg;

    opcode_t          op_reg;
    logic [KEY_W-1:0] key_reg;

    logic [LEN_W-1:0]   code_len_reg,  code_len_next;
    logic [LEN_W-1:0]   entry_len_reg, entry_len_next;
    logic               locked_reg,    locked_next;
    logic               set_reg,       set_next;
    logic [SWEEP_W-1:0] sweep_reg,     sweep_next;
    logic [FLASH_W-1:0] flash_reg,     flash_next;
    logic               prev_hash_reg, prev_hash_next;
    logic               done_reg,      done_next;
    logic               match_reg,     match_next;
    logic               full_reg,      full_next;
    logic [LEN_W-1:0]   idx_reg,       idx_next;
    logic               pend_reg,      pend_next;

    logic             code_we;
    logic             entry_we;
    logic             code_room;
    logic             entry_room;
    logic [LEN_W-1:0] entry_len_inc;
    logic             attempt;
    logic             cmp_done;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= opcode_t'(in_opcode);
            key_reg <= in_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (code_we) code_mem[code_len_reg[ADDR_W-1:0]] <= key_reg;
        code_rd_reg <= code_mem[idx_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (entry_we) entry_mem[entry_len_reg[ADDR_W-1:0]] <= key_reg;
        entry_rd_reg <= entry_mem[idx_reg[ADDR_W-1:0]];
    end

    assign code_room     = code_len_reg < LEN_W'(MAX_CODE_LEN);
    assign entry_room    = entry_len_reg < LEN_W'(MAX_CODE_LEN);
    assign entry_len_inc = entry_len_reg + {{(LEN_W-1){1'b0}}, entry_room};
    assign attempt       = (op_reg == OP_KEY) && locked_reg && (entry_len_inc >= code_len_reg);
    // The walk is over once every digit has been read and the last one compared.
    assign cmp_done      = (idx_reg == code_len_reg) && !pend_reg;

    assign status.need_cmp = attempt;
    assign status.cmp_done = cmp_done;

    always_comb begin
        code_len_next  = code_len_reg;
        entry_len_next = entry_len_reg;
        locked_next    = locked_reg;
        set_next       = set_reg;
        sweep_next     = sweep_reg;
        flash_next     = flash_reg;
        prev_hash_next = prev_hash_reg;
        done_next      = done_reg;
        match_next     = match_reg;
        full_next      = full_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        code_we        = 1'b0;
        entry_we       = 1'b0;

        if (cmd.exec) begin
            done_next  = 1'b0;
            match_next = 1'b0;
            full_next  = 1'b0;
            unique case (op_reg)
                OP_KEY: begin
                    if (!locked_reg && !set_reg) begin
                        if (code_room) begin
                            code_we        = 1'b1;
                            code_len_next  = code_len_reg + 1'b1;
                            prev_hash_next = (key_reg == KEY_HASH);
                            // Two hash keys in a row close the code and lock the bolt.
                            if ((key_reg == KEY_HASH) && prev_hash_reg &&
                                (code_len_reg != '0)) begin
                                locked_next = 1'b1;
                                set_next    = 1'b1;
                            end
                        end else begin
                            full_next = 1'b1;
                        end
                    end else if (locked_reg) begin
                        entry_we       = entry_room;
                        full_next      = !entry_room;
                        entry_len_next = entry_len_inc;
                        if (attempt) begin
                            done_next      = 1'b1;
                            match_next     = 1'b1;
                            entry_len_next = '0;
                            flash_next     = flash_ticks;
                            idx_next       = '0;
                            pend_next      = 1'b0;
                        end
                    end
                end
                OP_BOX_CLOSED: begin
                    if (set_reg) begin
                        locked_next    = 1'b1;
                        entry_len_next = '0;
                    end
                end
                OP_RESET_PRESS: begin
                    code_len_next = '0;
                end
                OP_RESET_RELEASE: begin
                    locked_next = 1'b0;
                    set_next    = 1'b0;
                end
                OP_TICK: begin
                    if (flash_reg != '0) begin
                        flash_next = flash_reg - 1'b1;
                    end else if (locked_reg) begin
                        sweep_next = '0;
                    end else if (sweep_reg == SWEEP_W'(LED_COUNT - 1)) begin
                        sweep_next = '0;
                    end else begin
                        sweep_next = sweep_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.cmp_step) begin
            if (pend_reg && (code_rd_reg != entry_rd_reg)) match_next = 1'b0;
            pend_next = idx_reg < code_len_reg;
            if (idx_reg < code_len_reg) idx_next = idx_reg + 1'b1;
            if (cmp_done && match_reg) locked_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_len_reg  <= '0;
            entry_len_reg <= '0;
            locked_reg    <= 1'b0;
            set_reg       <= 1'b0;
            sweep_reg     <= '0;
            flash_reg     <= '0;
            prev_hash_reg <= 1'b0;
            done_reg      <= 1'b0;
            match_reg     <= 1'b0;
            full_reg      <= 1'b0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
        end else begin
            code_len_reg  <= code_len_next;
            entry_len_reg <= entry_len_next;
            locked_reg    <= locked_next;
            set_reg       <= set_next;
            sweep_reg     <= sweep_next;
            flash_reg     <= flash_next;
            prev_hash_reg <= prev_hash_next;
            done_reg      <= done_next;
            match_reg     <= match_next;
            full_reg      <= full_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
        end
    end

    always_comb begin
        result               = '0;
        result.is_locked     = locked_reg;
        result.code_set      = set_reg;
        result.servo_pulse   = locked_reg ? lock_pulse : open_pulse;
        result.attempt_done  = done_reg;
        result.attempt_match = match_reg;
        result.store_full    = full_reg;
        if (flash_reg != '0) begin
            result.leds = LED_ALL;
        end else if (locked_reg) begin
            result.leds = '0;
        end else begin
            result.leds = LED_ALL & (LED_W'(1) << sweep_reg);
        end
    end

endmodule

### src/keypad_code_lock.sv
// Usage:
// Events arrive on the s_ stream, one beat each: s_tuser carries the opcode
// (key, box closed, reset pressed, reset released, tick) and s_tdata the key
// index. Every event produces exactly one result beat on the m_ stream with
// the lock state, servo pulse, LED pattern and attempt flags.
// Servo pulse widths and the flash length are set over the APB port at
// byte addresses 0, 4 and 8; write them only while no event is in flight.
// An event that completes an entry walks the stored code one digit per cycle
// through the code and entry memories; the stored code is at most 16 keys
// long. Each event is accepted in the idle state, executed in the exec state,
// compared in the compare state if it completes an entry, and its result beat
// is loaded into the output register in the finish state; s_tready stays low
// from accept until the controller is back in the idle state.
// The output register holds one result; s_tready comes back while a result
// is still waiting, and the next event is worked through and then held until
// the receiver takes the waiting beat.
// Reset clears the code, entry, lock and LED state and restores the register
// defaults (271, 1, 2); store contents are only read once written again.
`timescale 1ns / 1ps

module keypad_code_lock
    import klock_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [3:0] key_index, [7:4] zero
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [2:0] opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] is_locked, [1] code_set, [14:2] servo_pulse, [19:15] leds,
    // [20] attempt_done, [21] attempt_match, [22] store_full, [23] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [PULSE_W-1:0] lock_pulse_reg;
    logic [PULSE_W-1:0] open_pulse_reg;
    logic [FLASH_W-1:0] flash_ticks_reg;
    logic               cfg_write;

    logic               m_tvalid_reg, m_tvalid_next;
    result_t            m_tdata_reg;

    cmd_t               cmd;
    status_t            status;
    result_t            result;
    logic               out_free;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_pulse_reg  <= LOCK_PULSE_RESET;
            open_pulse_reg  <= OPEN_PULSE_RESET;
            flash_ticks_reg <= FLASH_TICKS_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_LOCK_PULSE:  lock_pulse_reg  <= pwdata[PULSE_W-1:0];
                REG_OPEN_PULSE:  open_pulse_reg  <= pwdata[PULSE_W-1:0];
                REG_FLASH_TICKS: flash_ticks_reg <= pwdata[FLASH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LOCK_PULSE:  prdata = APB_DATA_W'(lock_pulse_reg);
            REG_OPEN_PULSE:  prdata = APB_DATA_W'(open_pulse_reg);
            REG_FLASH_TICKS: prdata = APB_DATA_W'(flash_ticks_reg);
            default:         prdata = '0;
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) m_tdata_reg <= result;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    klock_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .out_free (out_free),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    klock_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_opcode   (s_tuser[OP_W-1:0]),
        .in_key      (s_tdata[KEY_W-1:0]),
        .lock_pulse  (lock_pulse_reg),
        .open_pulse  (open_pulse_reg),
        .flash_ticks (flash_ticks_reg),
        .status      (status),
        .result      (result)
    );

endmodule

### src/klock_chk.sv
// Port-level checker for the keypad code lock, bound to the top level.
`timescale 1ns / 1ps

module klock_chk
    import klock_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [LED_W-1:0] leds;
    assign leds = m_tdata[19:15];

    // A result beat that is not taken stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    a_match_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21] |-> m_tdata[20])
        else $error("match reported without a completed attempt");

    // A locked bolt always has a confirmed code behind it.
    a_locked_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("locked without a code set");

    // LEDs are either the full flash, dark when locked, or a single sweep bit.
    a_leds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (leds == LED_ALL) ||
                     (m_tdata[0] && (leds == '0)) ||
                     (!m_tdata[0] && $onehot(leds)))
        else $error("illegal LED pattern");

endmodule

bind keypad_code_lock klock_chk u_klock_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
